// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define TAR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TAR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAR_ASSERT(label, clk, rst_n, prop, msg)
`define TAR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- src/tar_pkg.sv -----
package tar_pkg;

    localparam int ROWS        = 16;
    localparam int ROW_BYTES   = 43;
    localparam int STORE_DEPTH = ROWS * ROW_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        OP_BUS_WRITE = 2'd0,
        OP_BUS_READ  = 2'd1,
        OP_POLL      = 2'd2,
        OP_FRAME     = 2'd3
    } t_op;

    localparam logic [1:0] ADDR_CONTROL = 2'd0;
    localparam logic [1:0] ADDR_ROW     = 2'd1;
    localparam logic [1:0] ADDR_DATA    = 2'd2;
    localparam logic [1:0] ADDR_ACK     = 2'd3;

    localparam logic CFG_ENABLE = 1'b0;

    localparam logic [7:0] IE_MASK        = 8'h0c;
    localparam logic [7:0] STATUS_BASE    = 8'hef;
    localparam logic [7:0] LEAD_BYTE      = 8'h67;
    localparam logic [7:0] DISABLED_READ  = 8'hff;
    localparam logic [3:0] FRAME_ROW_LAST = 4'd13;
    localparam logic [5:0] FRAME_COL_LAST = 6'(ROW_BYTES - 1);
    localparam logic [5:0] COL_WRAP       = 6'(ROW_BYTES);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic load_direct;
        logic load_read;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic store_read;
    } t_status;

    function automatic logic [STORE_AW-1:0] store_addr(input logic [3:0] row,
                                                       input logic [5:0] col);
        return STORE_AW'(row) * STORE_AW'(ROW_BYTES) + STORE_AW'(col);
    endfunction

endpackage

// ----- src/teletext_adapter_registers_unit.sv -----
// Channel   | Handshake                    | Payload
// input     | i_in_valid / o_in_stall      | operation, address, value, frame_row,
//           |                              | frame_col, frame_present
// output    | o_out_valid / i_out_stall    | read_data, irq, channel, channel_changed
// config    | APB psel/penable/pwrite      | adapter_enabled at byte address 0
//
// An item goes straight to the output register, except an enabled bus read of the row
// data register, which waits in the read state for the registered read of the row store.
// After reset the row store is cleared one entry per cycle, all 688 entries, and no
// item is accepted until that pass ends; configuration writes are taken at any time.
// A result waits in the output register while the output is stalled, and the next
// item is accepted in the cycle that result is taken.
`include "assert_macros.svh"

module teletext_adapter_registers_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_address,
    input  logic [7:0]  i_value,
    input  logic [3:0]  i_frame_row,
    input  logic [5:0]  i_frame_col,
    input  logic        i_frame_present,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_irq,
    output logic [1:0]  o_channel,
    output logic        o_channel_changed
);

    logic             r_enabled;
    logic             cfg_write;
    tar_pkg::t_cmd    cmd;
    tar_pkg::t_status stat;

    assign o_pready  = 1'b1;
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata  = (i_paddr[2] == tar_pkg::CFG_ENABLE) ? {31'd0, r_enabled} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (cfg_write && (i_paddr[2] == tar_pkg::CFG_ENABLE)) begin
            r_enabled <= i_pwdata[0];
        end
    end

    tar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    tar_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_enabled         (r_enabled),
        .i_operation       (i_operation),
        .i_address         (i_address),
        .i_value           (i_value),
        .i_frame_row       (i_frame_row),
        .i_frame_col       (i_frame_col),
        .i_frame_present   (i_frame_present),
        .o_read_data       (o_read_data),
        .o_irq             (o_irq),
        .o_channel         (o_channel),
        .o_channel_changed (o_channel_changed)
    );

    `TAR_ASSERT(a_one_action, i_clk, i_rst_n, $onehot0({cmd.clear_step, cmd.load_direct, cmd.load_read}), "more than one datapath action in a cycle")
    `TAR_ASSERT(a_read_follows, i_clk, i_rst_n, (cmd.accept && stat.store_read) |=> cmd.load_read, "row data read did not complete in the next cycle")
    `TAR_ASSERT(a_load_shows, i_clk, i_rst_n, (cmd.load_direct || cmd.load_read) |=> o_out_valid, "loaded result is not presented")
    `TAR_ASSERT(a_no_accept_in_read, i_clk, i_rst_n, cmd.load_read |-> (!cmd.accept && o_in_stall), "item accepted while a row read is in flight")

endmodule

// ----- src/tar_ram.sv -----
module tar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 688
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tar_ctrl.sv -----
module tar_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  tar_pkg::t_status i_stat,
    output tar_pkg::t_cmd    o_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid
);

    tar_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            slot_free;
    logic            accept;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign accept    = (r_state == tar_pkg::ST_IDLE) && slot_free && i_in_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tar_pkg::ST_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = tar_pkg::ST_IDLE;
                end
            end
            tar_pkg::ST_IDLE: begin
                if (accept && i_stat.store_read) begin
                    n_state = tar_pkg::ST_READ;
                end
            end
            tar_pkg::ST_READ: begin
                n_state = tar_pkg::ST_IDLE;
            end
            default: begin
                n_state = tar_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tar_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            tar_pkg::ST_IDLE: begin
                o_in_stall        = !slot_free;
                o_cmd.accept      = accept;
                o_cmd.load_direct = accept && !i_stat.store_read;
            end
            tar_pkg::ST_READ: begin
                o_cmd.load_read = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_direct || o_cmd.load_read) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tar_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- src/tar_dp.sv -----
module tar_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tar_pkg::t_cmd    i_cmd,
    output tar_pkg::t_status o_stat,
    input  logic             i_enabled,
    input  logic [1:0]       i_operation,
    input  logic [1:0]       i_address,
    input  logic [7:0]       i_value,
    input  logic [3:0]       i_frame_row,
    input  logic [5:0]       i_frame_col,
    input  logic             i_frame_present,
    output logic [7:0]       o_read_data,
    output logic             o_irq,
    output logic [1:0]       o_channel,
    output logic             o_channel_changed
);

    logic [3:0] r_rp, n_rp;
    logic [5:0] r_cp, n_cp;
    logic       r_ie, n_ie;
    logic       r_da, n_da;
    logic       r_ip, n_ip;
    logic [1:0] r_ch, n_ch;
    logic [7:0] r_lead [tar_pkg::ROWS];
    logic [tar_pkg::STORE_AW-1:0] r_clr;

    logic       r_lead_sel;
    logic [7:0] r_lead_val;

    logic [7:0] r_read_data;
    logic       r_irq;
    logic [1:0] r_channel;
    logic       r_changed;

    logic [5:0] col_cur;
    logic [5:0] col_inc;
    logic [7:0] rd;
    logic       changed;
    logic       lead_we;
    logic       lead_poll;
    logic       st_we;
    logic [tar_pkg::STORE_AW-1:0] st_waddr;
    logic [tar_pkg::STORE_AW-1:0] ptr_addr;
    logic       ram_we;
    logic [tar_pkg::STORE_AW-1:0] ram_waddr;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;
    logic       frame_ok;

    assign col_cur  = (r_cp >= tar_pkg::COL_WRAP) ? 6'd0 : r_cp;
    assign col_inc  = col_cur + 6'd1;
    assign ptr_addr = tar_pkg::store_addr(r_rp, col_cur);
    assign frame_ok = (i_frame_row >= 4'd1) && (i_frame_row <= tar_pkg::FRAME_ROW_LAST)
                   && (i_frame_col >= 6'd1) && (i_frame_col <= tar_pkg::FRAME_COL_LAST);

    assign o_stat.store_read = i_enabled && (tar_pkg::t_op'(i_operation) == tar_pkg::OP_BUS_READ)
                            && (i_address == tar_pkg::ADDR_DATA);
    assign o_stat.clear_last = (r_clr == tar_pkg::STORE_AW'(tar_pkg::STORE_DEPTH - 1));

    always_comb begin
        n_rp      = r_rp;
        n_cp      = r_cp;
        n_ie      = r_ie;
        n_da      = r_da;
        n_ip      = r_ip;
        n_ch      = r_ch;
        rd        = 8'd0;
        changed   = 1'b0;
        lead_we   = 1'b0;
        lead_poll = 1'b0;
        st_we     = 1'b0;
        st_waddr  = ptr_addr;
        if (!i_enabled) begin
            if (tar_pkg::t_op'(i_operation) == tar_pkg::OP_BUS_READ) begin
                rd = tar_pkg::DISABLED_READ;
            end
        end else begin
            unique case (tar_pkg::t_op'(i_operation))
                tar_pkg::OP_BUS_WRITE: begin
                    unique case (i_address)
                        tar_pkg::ADDR_CONTROL: begin
                            if ((i_value & tar_pkg::IE_MASK) == tar_pkg::IE_MASK) begin
                                n_ie = 1'b1;
                            end
                            if ((i_value & tar_pkg::IE_MASK) == 8'd0) begin
                                n_ie = 1'b0;
                            end
                            if (!i_value[4]) begin
                                n_da = 1'b0;
                            end
                            if (i_value[1:0] != r_ch) begin
                                n_ch    = i_value[1:0];
                                n_da    = 1'b0;
                                n_rp    = 4'd0;
                                n_cp    = 6'd0;
                                changed = 1'b1;
                            end
                        end
                        tar_pkg::ADDR_ROW: begin
                            n_rp = i_value[3:0];
                            n_cp = 6'd0;
                        end
                        tar_pkg::ADDR_DATA: begin
                            n_cp = col_inc;
                            if (col_cur == 6'd0) begin
                                lead_we = 1'b1;
                            end else begin
                                st_we = 1'b1;
                            end
                        end
                        tar_pkg::ADDR_ACK: begin
                            n_da = 1'b0;
                        end
                        default: begin
                            n_da = r_da;
                        end
                    endcase
                end
                tar_pkg::OP_BUS_READ: begin
                    if (i_address == tar_pkg::ADDR_CONTROL) begin
                        rd   = tar_pkg::STATUS_BASE | {3'd0, r_da, 4'd0};
                        n_ip = 1'b0;
                    end else if (i_address == tar_pkg::ADDR_DATA) begin
                        n_cp = col_inc;
                    end
                end
                tar_pkg::OP_POLL: begin
                    n_da = 1'b1;
                    if (i_frame_present && r_ie) begin
                        n_ip      = 1'b1;
                        n_rp      = 4'd0;
                        n_cp      = 6'd0;
                        lead_poll = 1'b1;
                    end
                end
                tar_pkg::OP_FRAME: begin
                    if (frame_ok) begin
                        st_we    = 1'b1;
                        st_waddr = tar_pkg::store_addr(i_frame_row, i_frame_col);
                    end
                end
                default: begin
                    n_da = r_da;
                end
            endcase
        end
    end

    assign ram_we    = i_cmd.clear_step || (i_cmd.accept && st_we);
    assign ram_waddr = i_cmd.clear_step ? r_clr : st_waddr;
    assign ram_wdata = i_cmd.clear_step ? 8'd0 : i_value;

    tar_ram #(
        .WIDTH (8),
        .DEPTH (tar_pkg::STORE_DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (ptr_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp  <= 4'd0;
            r_cp  <= 6'd0;
            r_ie  <= 1'b0;
            r_da  <= 1'b0;
            r_ip  <= 1'b0;
            r_ch  <= 2'd0;
            r_clr <= '0;
            for (int i = 0; i < tar_pkg::ROWS; i++) begin
                r_lead[i] <= 8'd0;
            end
        end else begin
            if (i_cmd.clear_step && !o_stat.clear_last) begin
                r_clr <= r_clr + tar_pkg::STORE_AW'(1);
            end
            if (i_cmd.accept) begin
                r_rp <= n_rp;
                r_cp <= n_cp;
                r_ie <= n_ie;
                r_da <= n_da;
                r_ip <= n_ip;
                r_ch <= n_ch;
                if (lead_we) begin
                    r_lead[r_rp] <= i_value;
                end
                if (lead_poll) begin
                    for (int i = 0; i < tar_pkg::ROWS; i++) begin
                        r_lead[i] <= (i == 0 || i > int'(tar_pkg::FRAME_ROW_LAST))
                                   ? 8'd0 : tar_pkg::LEAD_BYTE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lead_sel <= (col_cur == 6'd0);
            r_lead_val <= r_lead[r_rp];
        end
        if (i_cmd.load_direct) begin
            r_read_data <= rd;
            r_irq       <= n_ip;
            r_channel   <= n_ch;
            r_changed   <= changed;
        end else if (i_cmd.load_read) begin
            r_read_data <= r_lead_sel ? r_lead_val : ram_rdata;
            r_irq       <= r_ip;
            r_channel   <= r_ch;
            r_changed   <= 1'b0;
        end
    end

    assign o_read_data       = r_read_data;
    assign o_irq             = r_irq;
    assign o_channel         = r_channel;
    assign o_channel_changed = r_changed;

endmodule
